// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    // Field widths of the channels.
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int OFFSET_W   = 11;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CELL_W     = 16;
    localparam int ATTR_W     = 8;
    localparam int PAGE_CFG_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Screen geometry.
    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int TAB_WIDTH     = 8;
    localparam int VISIBLE_CELLS = COLUMNS * ROWS;
    localparam int COPY_CELLS    = (ROWS - 1) * COLUMNS;

    // Defaults for the top level parameters.
    localparam int DEF_PAGES      = 4;
    localparam int DEF_PAGE_CELLS = 2048;

    // Cell and character constants.
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // Command codes of an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd_code;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTR = 1'd0,
        CFG_PAGE = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_W-1:0] cursor_offset;
        logic [COL_W-1:0]    cursor_column;
        logic [ROW_W-1:0]    cursor_row;
        logic [CELL_W-1:0]   cell_data;
        logic                scrolled;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic put;
        logic rd;
        logic init;
        logic clear;
        logic copy;
        logic blank;
        logic cnt_clr;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;
        logic clear_last;
        logic copy_last;
        logic blank_last;
        logic need_scroll;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/tcw_chan_if.sv =====
interface tcw_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [tcw_pkg::CMD_W-1:0] i_in_command,
    output logic                      o_in_ready,
    input  tcw_pkg::t_dp_sts          i_sts,
    output tcw_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_COPY,
        S_BLANK,
        S_CLEAR,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init = 1'b1;
                if (i_sts.init_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_in_command)
                        tcw_pkg::CMD_PUT:   n_state = S_PUT;
                        tcw_pkg::CMD_CLEAR: n_state = S_CLEAR;
                        tcw_pkg::CMD_READ:  n_state = S_READ;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = i_sts.need_scroll ? S_COPY : S_DONE;
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.copy_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_BLANK;
                end
            end
            S_BLANK: begin
                o_cmd.blank = 1'b1;
                if (i_sts.blank_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // State register; reset starts the memory sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/tcw_datapath.sv =====
module tcw_datapath #(
    parameter int PAGES      = tcw_pkg::DEF_PAGES,
    parameter int PAGE_CELLS = tcw_pkg::DEF_PAGE_CELLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_dp_cmd   i_cmd,
    output tcw_pkg::t_dp_sts   o_sts,
    input  tcw_pkg::t_in_item  i_in_data,
    input  logic               i_cfg_valid,
    input  tcw_pkg::t_cfg_item i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output tcw_pkg::t_out_item o_out_data
);

    localparam int TOTAL  = PAGES * PAGE_CELLS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int CNT_W  = $clog2(TOTAL + 1);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COLX_W = COL_W + 1;
    localparam int ROWX_W = ROW_W + 1;
    localparam int CELL_W = tcw_pkg::CELL_W;

    // Configuration and per-page cursor state.
    logic [tcw_pkg::ATTR_W-1:0]     r_attr;
    logic [tcw_pkg::PAGE_CFG_W-1:0] r_page;
    logic [COL_W-1:0]               r_col [PAGES];
    logic [ROW_W-1:0]               r_row [PAGES];

    // Item state.
    logic [tcw_pkg::CHAR_W-1:0] r_char;
    logic [tcw_pkg::IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0]          r_base;
    logic                       r_scrolled;
    logic                       r_rd_ok;
    logic [CNT_W-1:0]           r_cnt;

    // Cell memory and its registered read data.
    logic [CELL_W-1:0] r_mem [TOTAL];
    logic [CELL_W-1:0] r_rd_data;

    // Result register.
    logic               r_out_valid;
    tcw_pkg::t_out_item r_out;

    logic [PAGE_W-1:0]             w_psel;
    logic [tcw_pkg::PAGE_CFG_W:0]  w_page_ext;
    logic [COL_W-1:0]              w_cur_col;
    logic [ROW_W-1:0]              w_cur_row;
    logic [CELL_W-1:0]             w_blank;
    logic [COLX_W-1:0]             w_col_t;
    logic [ROWX_W-1:0]             w_row_t;
    logic [COL_W-1:0]              w_st_col;
    logic [CELL_W-1:0]             w_st_val;
    logic                          w_do_store;
    logic                          w_need_scroll;
    logic [ROW_W-1:0]              w_row_fin;
    logic                          w_wr_en;
    logic [ADDR_W-1:0]             w_wr_addr;
    logic [CELL_W-1:0]             w_wr_data;
    logic                          w_rd_en;
    logic [ADDR_W-1:0]             w_rd_addr;
    logic                          w_idx_ok;

    // Active page folded into the number of pages.
    always_comb begin
        w_page_ext = {1'b0, r_page};
        if (PAGES == 1) begin
            w_psel = '0;
        end else if (4'(w_page_ext) >= 4'(PAGES)) begin
            w_psel = PAGE_W'(w_page_ext - 3'(PAGES));
        end else begin
            w_psel = PAGE_W'(w_page_ext);
        end
    end

    assign w_cur_col = r_col[w_psel];
    assign w_cur_row = r_row[w_psel];
    assign w_blank   = {r_attr, tcw_pkg::BLANK_CHAR};
    assign w_idx_ok  = (32'(r_idx) < tcw_pkg::VISIBLE_CELLS);

    // Cursor movement and cell store of one put.
    always_comb begin
        w_col_t    = {1'b0, w_cur_col};
        w_row_t    = {1'b0, w_cur_row};
        w_st_col   = w_cur_col;
        w_st_val   = {r_attr, r_char};
        w_do_store = 1'b0;
        case (r_char)
            tcw_pkg::CH_BS: begin
                if (w_cur_col != '0) begin
                    w_col_t    = {1'b0, w_cur_col} - 1'b1;
                    w_st_col   = w_cur_col - 1'b1;
                    w_st_val   = w_blank;
                    w_do_store = 1'b1;
                end
            end
            tcw_pkg::CH_TAB: begin
                w_col_t = ({1'b0, w_cur_col} | COLX_W'(tcw_pkg::TAB_WIDTH - 1)) + 1'b1;
            end
            tcw_pkg::CH_CR: begin
                w_col_t = '0;
            end
            tcw_pkg::CH_LF: begin
                w_col_t = '0;
                w_row_t = {1'b0, w_cur_row} + 1'b1;
            end
            default: begin
                if (r_char >= tcw_pkg::BLANK_CHAR) begin
                    w_col_t    = {1'b0, w_cur_col} + 1'b1;
                    w_do_store = 1'b1;
                end
            end
        endcase
        // Wrap past the last column.
        if (32'(w_col_t) >= tcw_pkg::COLUMNS) begin
            w_col_t = '0;
            w_row_t = w_row_t + 1'b1;
        end
        w_need_scroll = (32'(w_row_t) >= tcw_pkg::ROWS);
        w_row_fin     = w_need_scroll ? ROW_W'(tcw_pkg::ROWS - 1) : ROW_W'(w_row_t);
    end

    // Memory write port select.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = '0;
        w_wr_data = w_blank;
        if (i_cmd.init) begin
            w_wr_en   = 1'b1;
            w_wr_addr = ADDR_W'(r_cnt);
            w_wr_data = tcw_pkg::RESET_CELL;
        end else if (i_cmd.clear) begin
            w_wr_en   = 1'b1;
            w_wr_addr = ADDR_W'(32'(r_base) + 32'(r_cnt));
        end else if (i_cmd.blank) begin
            w_wr_en   = 1'b1;
            w_wr_addr = ADDR_W'(32'(r_base) + tcw_pkg::COPY_CELLS + 32'(r_cnt));
        end else if (i_cmd.copy) begin
            w_wr_en   = (r_cnt != '0);
            w_wr_addr = ADDR_W'(32'(r_base) + 32'(r_cnt) - 1);
            w_wr_data = r_rd_data;
        end else if (i_cmd.put) begin
            w_wr_en   = w_do_store;
            w_wr_addr = ADDR_W'(32'(r_base) + 32'(w_cur_row) * tcw_pkg::COLUMNS
                                + 32'(w_st_col));
            w_wr_data = w_st_val;
        end
    end

    // Memory read port select; copy reads one row below the write.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if (i_cmd.copy) begin
            w_rd_en   = (32'(r_cnt) < tcw_pkg::COPY_CELLS);
            w_rd_addr = ADDR_W'(32'(r_base) + 32'(r_cnt) + tcw_pkg::COLUMNS);
        end else if (i_cmd.rd) begin
            w_rd_en   = w_idx_ok;
            w_rd_addr = ADDR_W'(32'(r_base) + 32'(r_idx));
        end
    end

    // Cell memory.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::RESET_ATTR;
            r_page <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_data.index)
                tcw_pkg::CFG_ATTR: r_attr <= i_cfg_data.value;
                tcw_pkg::CFG_PAGE: r_page <= i_cfg_data.value[tcw_pkg::PAGE_CFG_W-1:0];
                default:           r_attr <= r_attr;
            endcase
        end
    end

    // Cursors, sweep counter and result control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PAGES; p++) begin
                r_col[p] <= '0;
                r_row[p] <= '0;
            end
            r_cnt       <= '0;
            r_scrolled  <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.put) begin
                r_col[w_psel] <= COL_W'(w_col_t);
                r_row[w_psel] <= w_row_fin;
            end else if (i_cmd.clear) begin
                r_col[w_psel] <= '0;
                r_row[w_psel] <= '0;
            end

            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.init || i_cmd.clear || i_cmd.copy || i_cmd.blank) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (i_cmd.accept) begin
                r_scrolled <= 1'b0;
                r_rd_ok    <= 1'b0;
            end else begin
                if (i_cmd.put) begin
                    r_scrolled <= w_need_scroll;
                end
                if (i_cmd.rd) begin
                    r_rd_ok <= w_idx_ok;
                end
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_in_data.char_code;
            r_idx  <= i_in_data.cell_index;
            r_base <= ADDR_W'(32'(w_psel) * PAGE_CELLS);
        end
        if (i_cmd.finish) begin
            r_out.cursor_offset <= tcw_pkg::OFFSET_W'(32'(w_cur_row) * tcw_pkg::COLUMNS
                                                      + 32'(w_cur_col));
            r_out.cursor_column <= w_cur_col;
            r_out.cursor_row    <= w_cur_row;
            r_out.cell_data     <= r_rd_ok ? r_rd_data : '0;
            r_out.scrolled      <= r_scrolled;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status for the controller.
    assign o_sts.init_last   = (32'(r_cnt) == TOTAL - 1);
    assign o_sts.clear_last  = (32'(r_cnt) == tcw_pkg::VISIBLE_CELLS - 1);
    assign o_sts.copy_last   = (32'(r_cnt) == tcw_pkg::COPY_CELLS);
    assign o_sts.blank_last  = (32'(r_cnt) == tcw_pkg::COLUMNS - 1);
    assign o_sts.need_scroll = w_need_scroll;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    // A put always leaves the cursor inside the page.
    a_put_row_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |=> (32'(w_cur_row) < tcw_pkg::ROWS) && (32'(w_cur_col) < tcw_pkg::COLUMNS))
        else $error("cursor left the page after a put");

    // The blank-row sweep starts from a cleared counter after the copy.
    a_copy_to_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.copy && o_sts.copy_last) |=> (r_cnt == '0) && i_cmd.blank)
        else $error("bottom row blanking did not follow the copy");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // Only a read item returns cell contents.
    a_data_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put || i_cmd.clear) |=> !r_rd_ok)
        else $error("cell data flagged for a non-read item");

endmodule

// ===== rtl/text_console_writer_core.sv =====
// Flow: an accepted put or read runs its own step and then waits in the done state until
// the result register is free; the next item is taken back in idle. An unused command goes
// straight to done. A scrolling put adds a copy sweep of (ROWS-1)*COLUMNS cells and a sweep
// that blanks COLUMNS cells; a clear sweeps ROWS*COLUMNS cells, one cell at a time.
// Reset: synchronous, active low; afterwards the cell memory is swept to 0x0720, one cell
// a cycle (PAGES*PAGE_CELLS = 8192 cells) before the first item is taken.
module text_console_writer_core #(
    parameter int PAGES      = tcw_pkg::DEF_PAGES,
    parameter int PAGE_CELLS = tcw_pkg::DEF_PAGE_CELLS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    tcw_chan_if.sink   i_in,
    tcw_chan_if.source o_res,
    tcw_chan_if.sink   i_cfg
);

    tcw_pkg::t_dp_cmd  w_cmd;
    tcw_pkg::t_dp_sts  w_sts;
    tcw_pkg::t_in_item w_in_data;
    tcw_pkg::t_cfg_item w_cfg_data;
    tcw_pkg::t_out_item w_out_data;
    logic               w_out_valid;
    logic               w_in_ready;

    assign w_in_data  = i_in.data;
    assign w_cfg_data = i_cfg.data;

    // Register writes are taken in any cycle.
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_out_data;

    tcw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (w_in_data.command),
        .o_in_ready   (w_in_ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    tcw_datapath #(
        .PAGES      (PAGES),
        .PAGE_CELLS (PAGE_CELLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (w_in_data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (w_cfg_data),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .o_out_data  (w_out_data)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tcw_pkg::*;

    localparam int PAGES          = DEF_PAGES;
    localparam int PAGE_CELLS     = DEF_PAGE_CELLS;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 5;
    localparam longint LIMIT_CYCLES = 64'd8_000_000;
    localparam int PHASE_ITEMS    = 120;
    localparam int HOLD_AT_RESULT = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Stall patterns of the result receiver.
    typedef enum int {
        SINK_FREE,
        SINK_BUSY,
        SINK_SLOW
    } t_sink_mode;

    // Tracks the screen contents, cursors and registers, and holds the status
    // items that the block still owes.
    class console_tracker;
        bit [ATTR_W-1:0]     attribute;
        bit [PAGE_CFG_W-1:0] page;
        int                  column [PAGES];
        int                  row [PAGES];
        bit [CELL_W-1:0]     cells [PAGES*PAGE_CELLS];
        t_out_item           due_status [$];
        int                  errors;
        int                  results_seen;

        function new();
            attribute    = RESET_ATTR;
            page         = '0;
            errors       = 0;
            results_seen = 0;
            foreach (column[i]) begin
                column[i] = 0;
                row[i]    = 0;
            end
            foreach (cells[i]) begin
                cells[i] = RESET_CELL;
            end
        endfunction

        function bit [CELL_W-1:0] blank();
            return {attribute, BLANK_CHAR};
        endfunction

        function int active();
            return int'(page) % PAGES;
        endfunction

        function int cursor_spot();
            return row[active()] * COLUMNS + column[active()];
        endfunction

        function int pending();
            return due_status.size();
        endfunction

        function void note_register(t_cfg_item w);
            case (w.index)
                CFG_ATTR: attribute = w.value;
                CFG_PAGE: page = w.value[PAGE_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        // Applies one character to the active page; returns 1 when the page scrolled.
        function bit put_char(bit [CHAR_W-1:0] ch);
            int p;
            int b;
            int col;
            int rw;
            int i;
            p   = active();
            b   = p * PAGE_CELLS;
            col = column[p];
            rw  = row[p];
            if (ch == CH_BS) begin
                if (col != 0) begin
                    col--;
                    cells[b + rw * COLUMNS + col] = blank();
                end
            end else if (ch == CH_TAB) begin
                col = col + TAB_WIDTH - (col % TAB_WIDTH);
            end else if (ch == CH_CR) begin
                col = 0;
            end else if (ch == CH_LF) begin
                col = 0;
                rw++;
            end else if (ch >= BLANK_CHAR) begin
                cells[b + rw * COLUMNS + col] = {attribute, ch};
                col++;
            end
            // Wrap past the last column.
            if (col >= COLUMNS) begin
                col = 0;
                rw++;
            end
            column[p] = col;
            if (rw < ROWS) begin
                row[p] = rw;
                return 1'b0;
            end
            // Scroll up one row and blank the bottom row.
            for (i = 0; i < COPY_CELLS; i++) begin
                cells[b + i] = cells[b + i + COLUMNS];
            end
            for (i = COPY_CELLS; i < VISIBLE_CELLS; i++) begin
                cells[b + i] = blank();
            end
            row[p] = ROWS - 1;
            return 1'b1;
        endfunction

        // Works out the status item for one accepted command.
        function void take_command(t_in_item it);
            t_out_item due;
            int        p;
            int        b;
            int        i;
            due = '0;
            p   = active();
            b   = p * PAGE_CELLS;
            case (it.command)
                CMD_PUT: due.scrolled = put_char(it.char_code);
                CMD_CLEAR: begin
                    for (i = 0; i < VISIBLE_CELLS; i++) begin
                        cells[b + i] = blank();
                    end
                    column[p] = 0;
                    row[p]    = 0;
                end
                CMD_READ: begin
                    if (it.cell_index < VISIBLE_CELLS) begin
                        due.cell_data = cells[b + it.cell_index];
                    end
                end
                default: ;
            endcase
            due.cursor_offset = OFFSET_W'(row[p] * COLUMNS + column[p]);
            due.cursor_column = COL_W'(column[p]);
            due.cursor_row    = ROW_W'(row[p]);
            due_status.push_back(due);
        endfunction

        function void compare(string field, logic [CELL_W-1:0] want, logic [CELL_W-1:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, seen);
            end
        endfunction

        function void check_status(t_out_item got);
            t_out_item due;
            results_seen++;
            if (due_status.size() == 0) begin
                errors++;
                $display("%0t: unexpected status item, expected none, actual %0h", $time, got);
                return;
            end
            due = due_status.pop_front();
            compare("cursor_offset", CELL_W'(due.cursor_offset), CELL_W'(got.cursor_offset));
            compare("cursor_column", CELL_W'(due.cursor_column), CELL_W'(got.cursor_column));
            compare("cursor_row", CELL_W'(due.cursor_row), CELL_W'(got.cursor_row));
            compare("cell_data", due.cell_data, got.cell_data);
            compare("scrolled", CELL_W'(due.scrolled), CELL_W'(got.scrolled));
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    longint cycles = 0;

    tcw_chan_if #(.T(t_in_item))  in_ch ();
    tcw_chan_if #(.T(t_out_item)) res_ch ();
    tcw_chan_if #(.T(t_cfg_item)) cfg_ch ();

    console_tracker screen = new();

    text_console_writer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watch all three channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            screen.take_command(in_ch.data);
        end
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            screen.note_register(cfg_ch.data);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            screen.check_status(res_ch.data);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result receiver: changes its stall pattern now and then, and holds off
    // once for a long stretch so that the block backs up.
    initial begin : result_sink
        int         hold_left;
        int         mode_left;
        bit         hold_done;
        t_sink_mode mode;
        hold_left    = 0;
        mode_left    = 0;
        hold_done    = 1'b0;
        mode         = SINK_FREE;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (!hold_done && screen.results_seen >= HOLD_AT_RESULT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_FREE: res_ch.ready <= 1'b1;
                    SINK_BUSY: res_ch.ready <= ($urandom_range(0, 9) < 7);
                    default:   res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic t_in_item make_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                           logic [IDX_W-1:0] idx);
        t_in_item it;
        it.command    = cmd;
        it.char_code  = ch;
        it.cell_index = idx;
        return it;
    endfunction

    // Mostly text with line ends; lf_share adds extra line feeds to reach the
    // bottom row and scroll.
    function automatic t_in_item random_command(int lf_share);
        t_in_item it;
        int       pick;
        int       spot;
        it.command    = CMD_PUT;
        it.char_code  = CHAR_W'($urandom);
        it.cell_index = IDX_W'($urandom);
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < lf_share) begin
            it.char_code = CH_LF;
        end else if (pick < 55) begin
            it.char_code = CHAR_W'($urandom_range(BLANK_CHAR, 255));
        end else if (pick < 60) begin
            it.char_code = CH_LF;
        end else if (pick < 64) begin
            it.char_code = CH_CR;
        end else if (pick < 68) begin
            it.char_code = CH_TAB;
        end else if (pick < 73) begin
            it.char_code = CH_BS;
        end else if (pick < 77) begin
            it.char_code = CHAR_W'($urandom_range(0, BLANK_CHAR - 1));
        end else if (pick < 94) begin
            it.command = CMD_READ;
            // Half the reads look just behind the cursor, where text was written.
            if ($urandom_range(0, 1) == 0) begin
                spot = screen.cursor_spot() - $urandom_range(0, 2 * COLUMNS);
                it.cell_index = IDX_W'((spot < 0) ? 0 : spot);
            end
        end else if (pick < 95) begin
            it.command = CMD_CLEAR;
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic send_command(t_in_item it);
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Input idle with noise on the payload; the argument n sets the length of the gap.
    task automatic idle_input(int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            in_ch.data  <= {CMD_W'($urandom), CHAR_W'($urandom), IDX_W'($urandom)};
        end
    endtask

    task automatic set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: value};
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (screen.pending() != 0) @(posedge i_clk);
    endtask

    // One random phase under a fresh attribute and page.
    task automatic run_phase(logic [ATTR_W-1:0] attr, logic [PAGE_CFG_W-1:0] pg, int lf_share,
                             bit pause_midway);
        int                    sent;
        int                    burst;
        logic [CFG_DATA_W-1:0] page_value;
        wait_drained();
        page_value = CFG_DATA_W'($urandom);
        page_value[PAGE_CFG_W-1:0] = pg;
        set_register(CFG_ATTR, attr);
        set_register(CFG_PAGE, page_value);
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                send_command(random_command(lf_share));
                sent++;
            end
            // Let the block run dry once in the middle of the phase.
            if (pause_midway && sent >= PHASE_ITEMS / 2) begin
                idle_input(1);
                wait_drained();
                pause_midway = 1'b0;
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_input($urandom_range(1, 15));
            end
        end
        idle_input(1);
    endtask

    initial begin : stimulus
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items on page 0 with the reset attribute.
        send_command(make_item(CMD_READ, 8'h00, 11'd0));
        send_command(make_item(CMD_READ, 8'hFF, 11'd2047));
        send_command(make_item(CMD_PUT, 8'h41, 11'd0));
        send_command(make_item(CMD_PUT, 8'hFF, 11'd0));
        send_command(make_item(CMD_PUT, 8'h80, 11'd0));
        send_command(make_item(CMD_PUT, 8'h7F, 11'd0));
        send_command(make_item(CMD_PUT, BLANK_CHAR, 11'd0));
        send_command(make_item(CMD_READ, 8'h00, 11'd1));
        send_command(make_item(CMD_PUT, CH_BS, 11'd0));
        send_command(make_item(CMD_READ, 8'h00, 11'd4));
        send_command(make_item(CMD_PUT, CH_TAB, 11'd0));
        send_command(make_item(CMD_PUT, CH_TAB, 11'd0));
        send_command(make_item(CMD_PUT, CH_CR, 11'd0));
        send_command(make_item(CMD_PUT, CH_BS, 11'd0));
        send_command(make_item(CMD_PUT, CH_LF, 11'd0));
        send_command(make_item(CMD_PUT, 8'h00, 11'd0));
        send_command(make_item(CMD_PUT, 8'h1F, 11'd0));
        send_command(make_item(CMD_PUT, 8'h0B, 11'd0));
        send_command(make_item(CMD_UNUSED, 8'hFF, 11'd2047));
        send_command(make_item(CMD_READ, 8'h00, 11'd1999));
        send_command(make_item(CMD_READ, 8'h00, 11'd2000));
        send_command(make_item(CMD_CLEAR, 8'h00, 11'd0));
        send_command(make_item(CMD_READ, 8'h00, 11'd0));
        idle_input(1);

        // Random phases across pages and attributes, the extremes first.
        run_phase(8'hFF, 2'd3, 30, 1'b0);
        run_phase(8'h00, 2'd1, 5, 1'b0);
        run_phase(ATTR_W'($urandom), 2'd2, 15, 1'b1);
        run_phase(ATTR_W'($urandom), 2'd0, 25, 1'b0);
        run_phase(ATTR_W'($urandom), 2'd3, 10, 1'b0);
        run_phase(ATTR_W'($urandom), 2'd1, 40, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (screen.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
